[hw/rtl/stbl_pkg.sv]
package stbl_pkg;

    localparam int MAX_PIXELS = 307200;
    localparam int ADDR_W     = 19;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_PIXELS - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_HUE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_WEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 3'd5;

    localparam logic [8:0]  RST_HUE          = 9'd30;
    localparam logic [8:0]  RST_SAT_GAIN     = 9'd115;
    localparam logic [8:0]  RST_VALUE_GAIN   = 9'd269;
    localparam logic [8:0]  RST_GHOST_WEIGHT = 9'd102;
    localparam logic [8:0]  RST_HIST_WEIGHT  = 9'd154;
    localparam logic [18:0] RST_FRAME_PIXELS = 19'd307200;

    localparam logic [12:0] Q_ONE  = 13'd4096;
    localparam logic [8:0]  W_ONE  = 9'd256;

    typedef struct packed {
        logic [8:0]  hue;
        logic [8:0]  sat_gain;
        logic [8:0]  value_gain;
        logic [8:0]  ghost_weight;
        logic [8:0]  hist_weight;
        logic [18:0] frame_pixels;
    } t_cfg;

    typedef struct packed {
        logic [7:0]        mx;
        logic [7:0]        mn;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_item;

    typedef struct packed {
        logic clearing;
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              last;
        logic [7:0]        mx;
        logic [12:0]       v12;
    } t_ctl;

    // Rounded Q1.12 product of two fractions no larger than one.
    function automatic logic [12:0] qmul(logic [12:0] a, logic [12:0] b);
        logic [26:0] p;
        begin
            p = 27'(a) * 27'(b) + 27'd2048;
            return p[24:12];
        end
    endfunction

    function automatic logic [12:0] gain_clamp(logic [12:0] x, logic [8:0] g);
        logic [21:0] p;
        begin
            p = 22'(x) * 22'(g) + 22'd128;
            return (p[21:8] > 14'(Q_ONE)) ? Q_ONE : p[20:8];
        end
    endfunction

    function automatic logic [7:0] to_byte(logic [12:0] x);
        logic [20:0] p;
        begin
            p = 21'(x) * 21'd255 + 21'd2048;
            return (p[20:12] > 9'd255) ? 8'd255 : p[19:12];
        end
    endfunction

    // Weight w is already limited to 256; the sum never exceeds 255 after the shift.
    function automatic logic [7:0] mix(logic [8:0] w, logic [7:0] a, logic [7:0] b);
        logic [16:0] s;
        begin
            s = 17'(w) * 17'(a) + 17'(W_ONE - w) * 17'(b) + 17'd128;
            return s[15:8];
        end
    endfunction

    // round(mx*4096/255) by a reciprocal multiply and one correction step.
    function automatic logic [12:0] v12_of(logic [7:0] mx);
        logic [19:0] n;
        logic [33:0] p;
        logic [12:0] q0;
        logic [19:0] r;
        begin
            n  = {mx, 12'b0} + 20'd127;
            p  = 34'(n) * 34'd4112;
            q0 = p[32:20];
            r  = n - ((20'(q0) << 8) - 20'(q0));
            return (r >= 20'd255) ? q0 + 13'd1 : q0;
        end
    endfunction

    // One restoring division step: returns the quotient bit over the new remainder.
    function automatic logic [20:0] div_step(logic [19:0] rem, logic [7:0] d, int k);
        logic [19:0] sh;
        begin
            sh = 20'(d) << k;
            if (rem >= sh) begin
                return {1'b1, rem - sh};
            end
            return {1'b0, rem};
        end
    endfunction

endpackage

[hw/rtl/stbl_front.sv]
module stbl_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [stbl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [stbl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output stbl_pkg::t_cfg                      o_cfg,
    input  logic                                i_accept,
    input  logic [7:0]                          i_red,
    input  logic [7:0]                          i_green,
    input  logic [7:0]                          i_blue,
    output stbl_pkg::t_item                     o_item
);

    stbl_pkg::t_cfg                  r_cfg;
    logic [stbl_pkg::ADDR_W-1:0]     r_pos;
    logic [stbl_pkg::ADDR_W-1:0]     n_pos;
    logic [18:0]                     len;
    logic [19:0]                     pos_inc;
    logic                            last;
    logic [7:0]                      mx_rg;
    logic [7:0]                      mn_rg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue          <= stbl_pkg::RST_HUE;
            r_cfg.sat_gain     <= stbl_pkg::RST_SAT_GAIN;
            r_cfg.value_gain   <= stbl_pkg::RST_VALUE_GAIN;
            r_cfg.ghost_weight <= stbl_pkg::RST_GHOST_WEIGHT;
            r_cfg.hist_weight  <= stbl_pkg::RST_HIST_WEIGHT;
            r_cfg.frame_pixels <= stbl_pkg::RST_FRAME_PIXELS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stbl_pkg::CFG_HUE:          r_cfg.hue          <= i_cfg_data[8:0];
                stbl_pkg::CFG_SAT_GAIN:     r_cfg.sat_gain     <= i_cfg_data[8:0];
                stbl_pkg::CFG_VALUE_GAIN:   r_cfg.value_gain   <= i_cfg_data[8:0];
                stbl_pkg::CFG_GHOST_WEIGHT: r_cfg.ghost_weight <= i_cfg_data[8:0];
                stbl_pkg::CFG_HIST_WEIGHT:  r_cfg.hist_weight  <= i_cfg_data[8:0];
                stbl_pkg::CFG_FRAME_PIXELS: r_cfg.frame_pixels <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    always_comb begin
        priority if (r_cfg.frame_pixels == 19'd0) begin
            len = 19'd1;
        end else if (r_cfg.frame_pixels > 19'(stbl_pkg::MAX_PIXELS)) begin
            len = 19'(stbl_pkg::MAX_PIXELS);
        end else begin
            len = r_cfg.frame_pixels;
        end
        pos_inc = 20'(r_pos) + 20'd1;
        last    = (pos_inc >= 20'(len));
        n_pos   = last ? '0 : pos_inc[stbl_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    always_comb begin
        mx_rg = (i_green > i_red) ? i_green : i_red;
        mn_rg = (i_green < i_red) ? i_green : i_red;
        o_item.mx   = (i_blue > mx_rg) ? i_blue : mx_rg;
        o_item.mn   = (i_blue < mn_rg) ? i_blue : mn_rg;
        o_item.addr = r_pos;
        o_item.last = last;
    end

endmodule

[hw/rtl/stbl_queue.sv]
module stbl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stbl_pkg::t_item i_data,
    output logic            o_full,
    input  logic            i_pop,
    output stbl_pkg::t_item o_data,
    output logic            o_empty
);

    localparam int DEPTH = 4;

    stbl_pkg::t_item r_ent [DEPTH];
    logic [1:0]      r_wr;
    logic [1:0]      r_rd;
    logic [2:0]      r_cnt;

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

endmodule

[hw/rtl/stbl_back.sv]
module stbl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stbl_pkg::t_cfg   i_cfg,
    input  stbl_pkg::t_item  i_item,
    input  logic             i_item_empty,
    output logic             o_item_pop,
    output stbl_pkg::t_status o_status,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic             o_frame_end,
    output logic             o_empty,
    input  logic             i_pop
);

    localparam int DIV_STAGES = 7;
    localparam int OUT_DEPTH  = 16;

    // ---------------- settings derived from the registers ----------------
    logic [8:0]  hue_mod;
    logic [8:0]  sext_base;
    logic [2:0]  sext_c;
    logic [2:0]  r_sext;
    logic [5:0]  r_hrem;
    logic [12:0] r_f12;
    logic [8:0]  r_gw;
    logic [8:0]  r_hw;
    logic [15:0] f_m;
    logic [29:0] f_p;
    logic [12:0] f_q0;
    logic [16:0] f_r;

    always_comb begin
        hue_mod = (i_cfg.hue >= 9'd360) ? i_cfg.hue - 9'd360 : i_cfg.hue;
        priority if (hue_mod >= 9'd300) begin
            sext_c = 3'd5; sext_base = 9'd300;
        end else if (hue_mod >= 9'd240) begin
            sext_c = 3'd4; sext_base = 9'd240;
        end else if (hue_mod >= 9'd180) begin
            sext_c = 3'd3; sext_base = 9'd180;
        end else if (hue_mod >= 9'd120) begin
            sext_c = 3'd2; sext_base = 9'd120;
        end else if (hue_mod >= 9'd60) begin
            sext_c = 3'd1; sext_base = 9'd60;
        end else begin
            sext_c = 3'd0; sext_base = 9'd0;
        end
        // round(rem*4096/60) = floor((rem*1024 + 7) / 15)
        f_m  = {r_hrem, 10'b0} + 16'd7;
        f_p  = 30'(f_m) * 30'd4369;
        f_q0 = f_p[28:16];
        f_r  = 17'(f_m) - ((17'(f_q0) << 4) - 17'(f_q0));
    end

    always_ff @(posedge i_clk) begin
        r_sext <= sext_c;
        r_hrem <= 6'(hue_mod - sext_base);
        r_f12  <= (f_r >= 17'd15) ? f_q0 + 13'd1 : f_q0;
        r_gw   <= (i_cfg.ghost_weight > stbl_pkg::W_ONE) ? stbl_pkg::W_ONE : i_cfg.ghost_weight;
        r_hw   <= (i_cfg.hist_weight > stbl_pkg::W_ONE) ? stbl_pkg::W_ONE : i_cfg.hist_weight;
    end

    // ---------------- history clearing pass and flow control ----------------
    logic                        r_clearing;
    logic [stbl_pkg::ADDR_W-1:0] r_clr_addr;
    logic [4:0]                  r_used;
    logic                        out_pop;

    assign o_status.clearing = r_clearing;
    assign o_item_pop = !i_item_empty && !r_clearing && (r_used < 5'(OUT_DEPTH));
    assign out_pop    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_used     <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == stbl_pkg::LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            // Every item taken in holds a place in the result queue until it is popped.
            r_used <= r_used + 5'(o_item_pop) - 5'(out_pop);
        end
    end

    // ---------------- entry stage ----------------
    stbl_pkg::t_ctl r_p0_ctl;
    logic [7:0]     r_p0_mn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_ctl <= '0;
        end else begin
            r_p0_ctl.valid <= o_item_pop;
            r_p0_ctl.addr  <= i_item.addr;
            r_p0_ctl.last  <= i_item.last;
            r_p0_ctl.mx    <= i_item.mx;
            r_p0_ctl.v12   <= stbl_pkg::v12_of(i_item.mx);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_mn <= i_item.mn;
    end

    // Saturation divider, two quotient bits a stage and one in the last stage.
    stbl_pkg::t_ctl r_d_ctl [DIV_STAGES];
    logic [19:0]    r_d_rem [DIV_STAGES];
    logic [12:0]    r_d_q   [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        stbl_pkg::t_ctl c_in;
        logic [19:0]    rem_in;
        logic [12:0]    q_in;
        logic [20:0]    st_a;
        logic [19:0]    rem_out;
        logic [12:0]    q_out;

        if (j == 0) begin : g_first
            assign c_in   = r_p0_ctl;
            assign rem_in = {r_p0_ctl.mx - r_p0_mn, 12'b0} + 20'(r_p0_ctl.mx >> 1);
            assign q_in   = '0;
        end else begin : g_next
            assign c_in   = r_d_ctl[j-1];
            assign rem_in = r_d_rem[j-1];
            assign q_in   = r_d_q[j-1];
        end

        assign st_a = stbl_pkg::div_step(rem_in, c_in.mx, 12 - 2 * j);

        if (2 * j < 12) begin : g_two
            logic [20:0] st_b;
            assign st_b    = stbl_pkg::div_step(st_a[19:0], c_in.mx, 11 - 2 * j);
            assign rem_out = st_b[19:0];
            assign q_out   = q_in | (13'(st_a[20]) << (12 - 2 * j))
                                  | (13'(st_b[20]) << (11 - 2 * j));
        end else begin : g_one
            assign rem_out = st_a[19:0];
            assign q_out   = q_in | (13'(st_a[20]) << (12 - 2 * j));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_ctl[j] <= '0;
            end else begin
                r_d_ctl[j] <= c_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_d_rem[j] <= rem_out;
            r_d_q[j]   <= q_out;
        end
    end

    // ---------------- gains ----------------
    stbl_pkg::t_ctl r_g_ctl;
    logic [12:0]    r_g_s;
    logic [12:0]    r_g_v;
    logic [12:0]    s_raw;

    assign s_raw = (r_d_ctl[DIV_STAGES-1].mx == 8'd0) ? '0 : r_d_q[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_ctl <= '0;
        end else begin
            r_g_ctl <= r_d_ctl[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_s <= stbl_pkg::gain_clamp(s_raw, i_cfg.sat_gain);
        r_g_v <= stbl_pkg::gain_clamp(r_d_ctl[DIV_STAGES-1].v12, i_cfg.value_gain);
    end

    // ---------------- HSV rebuild ----------------
    stbl_pkg::t_ctl r_h1_ctl;
    stbl_pkg::t_ctl r_h2_ctl;
    logic [12:0]    r_h1_p, r_h1_sf, r_h1_sg, r_h1_v;
    logic           r_h1_grey;
    logic [12:0]    r_h2_p, r_h2_q, r_h2_t, r_h2_v;
    logic           r_h2_grey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_ctl <= '0;
            r_h2_ctl <= '0;
        end else begin
            r_h1_ctl <= r_g_ctl;
            r_h2_ctl <= r_h1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h1_p    <= stbl_pkg::qmul(r_g_v, stbl_pkg::Q_ONE - r_g_s);
        r_h1_sf   <= stbl_pkg::qmul(r_g_s, r_f12);
        r_h1_sg   <= stbl_pkg::qmul(r_g_s, stbl_pkg::Q_ONE - r_f12);
        r_h1_v    <= r_g_v;
        r_h1_grey <= (r_g_s == 13'd0);
        r_h2_q    <= stbl_pkg::qmul(r_h1_v, stbl_pkg::Q_ONE - r_h1_sf);
        r_h2_t    <= stbl_pkg::qmul(r_h1_v, stbl_pkg::Q_ONE - r_h1_sg);
        r_h2_p    <= r_h1_p;
        r_h2_v    <= r_h1_v;
        r_h2_grey <= r_h1_grey;
    end

    // ---------------- tint bytes and history read ----------------
    stbl_pkg::t_ctl r_t_ctl;
    logic [7:0]     r_t_tint [3];
    logic [7:0]     vb, pb, qb, tb;
    logic [7:0]     tint_c [3];
    logic [23:0]    r_mem [stbl_pkg::MAX_PIXELS];
    logic [23:0]    r_rd;

    always_comb begin
        vb = stbl_pkg::to_byte(r_h2_v);
        pb = stbl_pkg::to_byte(r_h2_p);
        qb = stbl_pkg::to_byte(r_h2_q);
        tb = stbl_pkg::to_byte(r_h2_t);
        if (r_h2_grey) begin
            tint_c[0] = vb; tint_c[1] = vb; tint_c[2] = vb;
        end else begin
            unique case (r_sext)
                3'd0:    begin tint_c[0] = vb; tint_c[1] = tb; tint_c[2] = pb; end
                3'd1:    begin tint_c[0] = qb; tint_c[1] = vb; tint_c[2] = pb; end
                3'd2:    begin tint_c[0] = pb; tint_c[1] = vb; tint_c[2] = tb; end
                3'd3:    begin tint_c[0] = pb; tint_c[1] = qb; tint_c[2] = vb; end
                3'd4:    begin tint_c[0] = tb; tint_c[1] = pb; tint_c[2] = vb; end
                default: begin tint_c[0] = vb; tint_c[1] = pb; tint_c[2] = qb; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_ctl <= '0;
        end else begin
            r_t_ctl <= r_h2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_tint <= tint_c;
    end

    // ---------------- blend and history write ----------------
    logic                        r_w_valid;
    logic [stbl_pkg::ADDR_W-1:0] r_w_addr;
    logic                        r_w_last;
    logic [7:0]                  r_w_out [3];
    logic [23:0]                 r_w_nh;
    logic                        r_w2_valid;
    logic [stbl_pkg::ADDR_W-1:0] r_w2_addr;
    logic [23:0]                 r_w2_nh;
    logic [23:0]                 hist;
    logic [7:0]                  res_c [3];
    logic [23:0]                 nh_c;
    logic                        mem_we;
    logic [stbl_pkg::ADDR_W-1:0] mem_wa;
    logic [23:0]                 mem_wd;

    // The two newest updates have not reached the read port yet, so they are forwarded.
    always_comb begin
        priority if (r_w_valid && (r_w_addr == r_t_ctl.addr)) begin
            hist = r_w_nh;
        end else if (r_w2_valid && (r_w2_addr == r_t_ctl.addr)) begin
            hist = r_w2_nh;
        end else begin
            hist = r_rd;
        end
        for (int k = 0; k < 3; k++) begin
            res_c[k] = stbl_pkg::mix(r_gw, hist[23-8*k -: 8], r_t_tint[k]);
            nh_c[23-8*k -: 8] = stbl_pkg::mix(r_hw, hist[23-8*k -: 8], r_t_tint[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid  <= 1'b0;
            r_w2_valid <= 1'b0;
        end else begin
            r_w_valid  <= r_t_ctl.valid;
            r_w2_valid <= r_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_addr  <= r_t_ctl.addr;
        r_w_last  <= r_t_ctl.last;
        r_w_out   <= res_c;
        r_w_nh    <= nh_c;
        r_w2_addr <= r_w_addr;
        r_w2_nh   <= r_w_nh;
    end

    assign mem_we = r_clearing || r_w_valid;
    assign mem_wa = r_clearing ? r_clr_addr : r_w_addr;
    assign mem_wd = r_clearing ? '0 : r_w_nh;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[r_h2_ctl.addr];
    end

    // ---------------- result queue ----------------
    logic [24:0] r_of [OUT_DEPTH];
    logic [3:0]  r_of_wr;
    logic [3:0]  r_of_rd;
    logic [4:0]  r_of_cnt;

    always_ff @(posedge i_clk) begin
        if (r_w_valid) begin
            r_of[r_of_wr] <= {r_w_out[0], r_w_out[1], r_w_out[2], r_w_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_of_wr  <= '0;
            r_of_rd  <= '0;
            r_of_cnt <= '0;
        end else begin
            if (r_w_valid) begin
                r_of_wr <= r_of_wr + 4'd1;
            end
            if (out_pop) begin
                r_of_rd <= r_of_rd + 4'd1;
            end
            r_of_cnt <= r_of_cnt + 5'(r_w_valid) - 5'(out_pop);
        end
    end

    assign o_empty     = (r_of_cnt == 5'd0);
    assign o_red_out   = r_of[r_of_rd][24:17];
    assign o_green_out = r_of[r_of_rd][16:9];
    assign o_blue_out  = r_of[r_of_rd][8:1];
    assign o_frame_end = r_of[r_of_rd][0];

endmodule

[hw/rtl/sepia_tint_ghost_blend_top.sv]
// Sepia tint with temporal ghost blend, one RGB pixel per item.
// Input side is a queue write port: an item is taken when i_push is high and
// o_full is low. Results leave through a queue read port: the oldest result
// sits on the output ports while o_empty is low and is taken when i_pop is high.
// Each accepted pixel gives exactly one result, in order; o_frame_end marks
// the last pixel of a frame as counted by the internal pixel position.
// Settings are written over the i_cfg_valid / o_cfg_ready channel, index and
// data, and are meant to change only while no pixel is in flight.
// Throughput is one item per cycle while o_full is low; an accepted item runs
// through the 13 stage pipeline (entry, seven divider stages for saturation,
// gain, two HSV product stages, tint, blend) and then the result queue.
// The per-pixel history store is read one stage before the blend and written
// one stage after it, with the two newest updates forwarded.
// After reset all 307200 history entries are cleared, one a cycle, while o_full
// stays high; settings writes are taken throughout.
// When the receiver stalls, the result queue (16 items) fills and the input
// queue then backs up until o_full rises; nothing is dropped.
module sepia_tint_ghost_blend_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [7:0]                      i_red_in,
    input  logic [7:0]                      i_green_in,
    input  logic [7:0]                      i_blue_in,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic [7:0]                      o_red_out,
    output logic [7:0]                      o_green_out,
    output logic [7:0]                      o_blue_out,
    output logic                            o_frame_end,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [stbl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stbl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    stbl_pkg::t_cfg    cfg;
    stbl_pkg::t_item   front_item;
    stbl_pkg::t_item   mid_item;
    stbl_pkg::t_status status;
    logic              accept;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_full      = q_full || status.clearing;
    assign accept      = i_push && !o_full;

    stbl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .i_accept    (accept),
        .i_red       (i_red_in),
        .i_green     (i_green_in),
        .i_blue      (i_blue_in),
        .o_item      (front_item)
    );

    stbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (mid_item),
        .o_empty (q_empty)
    );

    stbl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (mid_item),
        .i_item_empty (q_empty),
        .o_item_pop   (q_pop),
        .o_status     (status),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_end  (o_frame_end),
        .o_empty      (o_empty),
        .i_pop        (i_pop)
    );

endmodule

[test/tb_top.sv]
module tb_top;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_pixel;

    typedef logic [stbl_pkg::CFG_DATA_W-1:0] t_cfg_data;

    // Keeps its own copy of the settings, the history store and the pixel
    // position, and predicts each result as items are accepted.
    class tint_blend_scoreboard;
        int unsigned hue, sat_gain, value_gain, ghost_w, hist_w, frame_len;
        int unsigned position;
        bit [23:0]   history [int unsigned];
        t_pixel      awaited [$];
        int          errors;
        int          checked;
        int          frame_ends;

        function new();
            hue        = stbl_pkg::RST_HUE;
            sat_gain   = stbl_pkg::RST_SAT_GAIN;
            value_gain = stbl_pkg::RST_VALUE_GAIN;
            ghost_w    = stbl_pkg::RST_GHOST_WEIGHT;
            hist_w     = stbl_pkg::RST_HIST_WEIGHT;
            frame_len  = stbl_pkg::RST_FRAME_PIXELS;
            position   = 0;
            errors     = 0;
            checked    = 0;
            frame_ends = 0;
        endfunction

        function void set_reg(logic [stbl_pkg::CFG_IDX_W-1:0] idx,
                              logic [stbl_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                stbl_pkg::CFG_HUE:          hue        = data[8:0];
                stbl_pkg::CFG_SAT_GAIN:     sat_gain   = data[8:0];
                stbl_pkg::CFG_VALUE_GAIN:   value_gain = data[8:0];
                stbl_pkg::CFG_GHOST_WEIGHT: ghost_w    = data[8:0];
                stbl_pkg::CFG_HIST_WEIGHT:  hist_w     = data[8:0];
                stbl_pkg::CFG_FRAME_PIXELS: frame_len  = data;
                default: ;
            endcase
        endfunction

        function int unsigned scale_clamp(int unsigned x, int unsigned g);
            int unsigned r;
            r = (x * g + 128) >> 8;
            return (r > 4096) ? 4096 : r;
        endfunction

        function int unsigned frac_mul(int unsigned a, int unsigned b);
            return (a * b + 2048) >> 12;
        endfunction

        function int unsigned to_level(int unsigned x);
            int unsigned r;
            r = (x * 255 + 2048) >> 12;
            return (r > 255) ? 255 : r;
        endfunction

        function int unsigned blend(int unsigned w, int unsigned a, int unsigned b);
            int unsigned r;
            if (w > 256) w = 256;
            r = (w * a + (256 - w) * b + 128) >> 8;
            return (r > 255) ? 255 : r;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned mx, mn, s12, v12, h, f12, p, q, t, vb, pb, qb, tb, len, pos;
            int unsigned tint [3];
            int unsigned old [3];
            int unsigned fresh [3];
            bit [23:0]   entry;
            t_pixel      px;
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            s12 = (mx != 0) ? ((mx - mn) * 4096 + mx / 2) / mx : 0;
            v12 = (mx * 4096 + 127) / 255;
            s12 = scale_clamp(s12, sat_gain);
            v12 = scale_clamp(v12, value_gain);
            if (s12 == 0) begin
                tint[0] = to_level(v12);
                tint[1] = tint[0];
                tint[2] = tint[0];
            end else begin
                h   = hue % 360;
                f12 = ((h % 60) * 4096 + 30) / 60;
                p   = frac_mul(v12, 4096 - s12);
                q   = frac_mul(v12, 4096 - frac_mul(s12, f12));
                t   = frac_mul(v12, 4096 - frac_mul(s12, 4096 - f12));
                vb = to_level(v12); pb = to_level(p); qb = to_level(q); tb = to_level(t);
                case (h / 60)
                    0: begin tint[0] = vb; tint[1] = tb; tint[2] = pb; end
                    1: begin tint[0] = qb; tint[1] = vb; tint[2] = pb; end
                    2: begin tint[0] = pb; tint[1] = vb; tint[2] = tb; end
                    3: begin tint[0] = pb; tint[1] = qb; tint[2] = vb; end
                    4: begin tint[0] = tb; tint[1] = pb; tint[2] = vb; end
                    default: begin tint[0] = vb; tint[1] = pb; tint[2] = qb; end
                endcase
            end
            len = (frame_len == 0) ? 1 : frame_len;
            if (len > stbl_pkg::MAX_PIXELS) len = stbl_pkg::MAX_PIXELS;
            pos = (position >= stbl_pkg::MAX_PIXELS) ? 0 : position;
            entry = history.exists(pos) ? history[pos] : 24'd0;
            old[0] = entry[23:16]; old[1] = entry[15:8]; old[2] = entry[7:0];
            for (int k = 0; k < 3; k++) begin
                fresh[k] = blend(hist_w, old[k], tint[k]);
                tint[k]  = blend(ghost_w, old[k], tint[k]);
            end
            history[pos] = {fresh[0][7:0], fresh[1][7:0], fresh[2][7:0]};
            px.red       = 8'(tint[0]);
            px.green     = 8'(tint[1]);
            px.blue      = 8'(tint[2]);
            px.frame_end = (pos + 1 >= len);
            position     = px.frame_end ? 0 : ((pos + 1) & 32'h7FFFF);
            awaited.push_back(px);
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
            t_pixel want;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing expected: %0d %0d %0d end %0b",
                         $time, r, g, b, fe);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (fe) frame_ends++;
            if (r !== want.red) begin
                $display("%0t: red expected %0d actual %0d", $time, want.red, r);
                errors++;
            end
            if (g !== want.green) begin
                $display("%0t: green expected %0d actual %0d", $time, want.green, g);
                errors++;
            end
            if (b !== want.blue) begin
                $display("%0t: blue expected %0d actual %0d", $time, want.blue, b);
                errors++;
            end
            if (fe !== want.frame_end) begin
                $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    // The clearing pass after reset, over all 307200 history entries, moves no item.
    localparam int STALL_LIMIT = 1200000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_push;
    logic                            o_full;
    logic [7:0]                      i_red_in, i_green_in, i_blue_in;
    logic                            o_empty;
    logic                            i_pop;
    logic [7:0]                      o_red_out, o_green_out, o_blue_out;
    logic                            o_frame_end;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [stbl_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [stbl_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tint_blend_scoreboard sb;
    bit calm;
    bit hold_req;
    int quiet_cycles;

    sepia_tint_ghost_blend_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (i_push && !o_full) begin
                sb.note_pixel(i_red_in, i_green_in, i_blue_in);
            end
            if (i_pop && !o_empty) begin
                sb.check_pixel(o_red_out, o_green_out, o_blue_out, o_frame_end);
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("FAIL sepia_tint_ghost_blend_top");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, a long hold-off on request, none at the end.
    initial begin
        i_pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_pop = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_pop = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else begin
                i_pop = 1'b1;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        @(negedge i_clk);
        i_push     = 1'b1;
        i_red_in   = r;
        i_green_in = g;
        i_blue_in  = b;
        while (o_full) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_push = 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [stbl_pkg::CFG_IDX_W-1:0] idx,
                             logic [stbl_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_push      = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(int unsigned h, int unsigned sg, int unsigned vg,
                             int unsigned gw, int unsigned hw, int unsigned fp);
        write_reg(stbl_pkg::CFG_HUE, t_cfg_data'(h));
        write_reg(stbl_pkg::CFG_SAT_GAIN, t_cfg_data'(sg));
        write_reg(stbl_pkg::CFG_VALUE_GAIN, t_cfg_data'(vg));
        write_reg(stbl_pkg::CFG_GHOST_WEIGHT, t_cfg_data'(gw));
        write_reg(stbl_pkg::CFG_HIST_WEIGHT, t_cfg_data'(hw));
        write_reg(stbl_pkg::CFG_FRAME_PIXELS, t_cfg_data'(fp));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_push = 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Mostly full-range pixels, with greys, a zero channel and pure extremes mixed in.
    task automatic random_pixels(int n);
        logic [7:0] r, g, b;
        for (int i = 0; i < n; i++) begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            case ($urandom_range(0, 9))
                0: begin g = r; b = r; end
                1: g = 8'd0;
                2: begin
                    r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                default: ;
            endcase
            sender_gap();
            send_pixel(r, g, b);
        end
    endtask

    initial begin
        sb          = new();
        calm        = 1'b0;
        hold_req    = 1'b0;
        quiet_cycles = 0;
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Settings as they come out of reset, then the corner pixels.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd170, 8'd85, 8'd255);
        send_pixel(8'd1, 8'd1, 8'd1);
        drain();

        // Lowest settings; single-pixel frames.
        write_all(0, 0, 0, 0, 0, 1);
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd12, 8'd200, 8'd7);
        drain();
        // Hue past 359, gains and weights past one, frame length past the store.
        write_all(511, 511, 511, 511, 511, 19'h7FFFF);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd10, 8'd20, 8'd30);
        send_pixel(8'd0, 8'd0, 8'd0);
        drain();
        // Zero frame length acts as one; hue at the top of its range.
        write_all(359, 256, 256, 256, 256, 0);
        send_pixel(8'd90, 8'd180, 8'd45);
        send_pixel(8'd255, 8'd255, 8'd0);
        drain();
        // Unused register slots are written and must change nothing.
        write_reg(3'd6, t_cfg_data'($urandom));
        write_reg(3'd7, t_cfg_data'($urandom));

        for (int ph = 0; ph < 8; ph++) begin
            write_all($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 511),
                      $urandom_range(0, 300), $urandom_range(0, 300),
                      (ph == 3) ? $urandom_range(1, 600000) : $urandom_range(0, 40));
            if (ph == 5) hold_req = 1'b1;
            if (ph == 7) calm = 1'b1;
            random_pixels(95);
            drain();
            // Shorten the frame after phase 2; the next write_all replaces it before any pixel.
            if (ph == 2) begin
                write_reg(stbl_pkg::CFG_FRAME_PIXELS, t_cfg_data'($urandom_range(1, 4)));
            end
        end

        @(negedge i_clk);
        i_push = 1'b0;
        drain();
        $display("Checked %0d pixels over %0d settings phases, %0d frame ends seen.",
                 sb.checked, 12, sb.frame_ends);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("PASS sepia_tint_ghost_blend_top");
        end else begin
            $display("FAIL sepia_tint_ghost_blend_top");
        end
        $finish;
    end

endmodule
